// ===== hdl/tcw_pkg.sv =====
// shared types, geometry constants and codes for the text console writer
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CELL_W  = 16;

    // character codes
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    // item kinds
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // reset value of the default attribute register
    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;

    // command payload
    typedef struct packed {
        logic [1:0] kind;
        logic       at_position;
        logic [6:0] column;
        logic [4:0] row;
        logic [7:0] character;
        logic [7:0] attribute;
    } cmd_t;

    // result payload
    typedef struct packed {
        logic [10:0] cursor_cell;
        logic        scrolled;
        logic [7:0]  read_character;
        logic [7:0]  read_attribute;
    } result_t;

    // cell memory access request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_DRAIN,
        ST_FILL
    } state_t;

endpackage

// ===== hdl/tcw_ram.sv =====
// simple dual-port cell memory, one write and one registered read per cycle
module tcw_ram #(
    parameter int DEPTH  = 2000,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tcw_ctrl.sv =====
// command sequencer: cursor, put/read/clear, scroll copy and fill sweeps
module tcw_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  tcw_pkg::cmd_t              cmd,
    input  logic [7:0]                 def_attr,
    output logic                       busy,
    output logic                       done,
    output tcw_pkg::result_t           result,
    output tcw_pkg::mem_req_t          mem_req,
    input  logic [tcw_pkg::CELL_W-1:0] mem_rdata
);

    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int ADDR_W = tcw_pkg::ADDR_W;
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(tcw_pkg::CELLS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW =
        ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_COPY =
        ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(tcw_pkg::COLUMNS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(tcw_pkg::COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(tcw_pkg::ROWS - 1);

    tcw_pkg::state_t   state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              zero_fill_reg, zero_fill_next;
    logic              init_reg, init_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              done_reg, done_next;
    tcw_pkg::result_t  res_reg, res_next;

    logic              accept;
    logic [COL_W-1:0]  sat_col, base_col, put_col, adv_col;
    logic [ROW_W-1:0]  sat_row, base_row, adv_row;
    logic              newline, wrap;
    logic [ADDR_W-1:0] base_addr, adv_addr, cur_addr;
    logic [7:0]        attr_eff;

    // decode of the command and cursor arithmetic
    always_comb
    begin
        accept  = start && (state_reg == tcw_pkg::ST_IDLE);
        sat_col = (32'(cmd.column) >= tcw_pkg::COLUMNS) ? LAST_COL : COL_W'(cmd.column);
        sat_row = (32'(cmd.row) >= tcw_pkg::ROWS) ? LAST_ROW : ROW_W'(cmd.row);
        base_col = cmd.at_position ? sat_col : col_reg;
        base_row = cmd.at_position ? sat_row : row_reg;
        newline  = (cmd.character == tcw_pkg::NEWLINE_CODE);
        put_col  = newline ? LAST_COL : base_col;
        wrap     = 1'b0;
        if (put_col == LAST_COL)
        begin
            adv_col = '0;
            if (base_row == LAST_ROW)
            begin
                adv_row = base_row;
                wrap    = 1'b1;
            end
            else
            begin
                adv_row = base_row + ROW_W'(1);
            end
        end
        else
        begin
            adv_col = put_col + COL_W'(1);
            adv_row = base_row;
        end
        base_addr = ADDR_W'(32'(base_row) * tcw_pkg::COLUMNS) + ADDR_W'(base_col);
        adv_addr  = ADDR_W'(32'(adv_row) * tcw_pkg::COLUMNS) + ADDR_W'(adv_col);
        cur_addr  = ADDR_W'(32'(row_reg) * tcw_pkg::COLUMNS) + ADDR_W'(col_reg);
        attr_eff  = (cmd.attribute == 8'd0) ? def_attr : cmd.attribute;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.kind)
                        tcw_pkg::KIND_PUT:   state_next = wrap ? tcw_pkg::ST_COPY
                                                               : tcw_pkg::ST_IDLE;
                        tcw_pkg::KIND_READ:  state_next = tcw_pkg::ST_READ;
                        tcw_pkg::KIND_CLEAR: state_next = tcw_pkg::ST_FILL;
                        default:             state_next = tcw_pkg::ST_IDLE;
                    endcase
                end
            end
            tcw_pkg::ST_READ:  state_next = tcw_pkg::ST_IDLE;
            tcw_pkg::ST_COPY:
            begin
                if (cnt_reg == LAST_COPY)
                begin
                    state_next = tcw_pkg::ST_DRAIN;
                end
            end
            tcw_pkg::ST_DRAIN: state_next = tcw_pkg::ST_FILL;
            tcw_pkg::ST_FILL:
            begin
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:           state_next = tcw_pkg::ST_IDLE;
        endcase
    end

    // memory requests, cursor and result updates
    always_comb
    begin
        mem_req.we     = 1'b0;
        mem_req.waddr  = cnt_reg;
        mem_req.wdata  = '0;
        mem_req.raddr  = base_addr;
        cnt_next       = cnt_reg;
        zero_fill_next = zero_fill_reg;
        init_next      = init_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        done_next      = 1'b0;
        res_next       = res_reg;
        case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.kind)
                        tcw_pkg::KIND_PUT:
                        begin
                            mem_req.we    = !newline;
                            mem_req.waddr = base_addr;
                            mem_req.wdata = {attr_eff, cmd.character};
                            col_next      = adv_col;
                            row_next      = adv_row;
                            if (wrap)
                            begin
                                cnt_next = '0;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                res_next  = '{cursor_cell: 11'(adv_addr), scrolled: 1'b0,
                                              read_character: 8'd0, read_attribute: 8'd0};
                            end
                        end
                        tcw_pkg::KIND_READ:
                        begin
                            mem_req.raddr = base_addr;
                        end
                        tcw_pkg::KIND_CLEAR:
                        begin
                            cnt_next       = '0;
                            zero_fill_next = 1'b0;
                            col_next       = '0;
                            row_next       = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            res_next  = '{cursor_cell: 11'(cur_addr), scrolled: 1'b0,
                                          read_character: 8'd0, read_attribute: 8'd0};
                        end
                    endcase
                end
            end
            tcw_pkg::ST_READ:
            begin
                done_next = 1'b1;
                res_next  = '{cursor_cell: 11'(cur_addr), scrolled: 1'b0,
                              read_character: mem_rdata[7:0],
                              read_attribute: mem_rdata[15:8]};
            end
            tcw_pkg::ST_COPY:
            begin
                // read one row ahead, write back the cell read last cycle
                mem_req.raddr  = cnt_reg + ROW_STEP;
                mem_req.we     = pend_reg;
                mem_req.waddr  = pend_addr_reg;
                mem_req.wdata  = mem_rdata;
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg;
                cnt_next       = cnt_reg + ADDR_W'(1);
                zero_fill_next = 1'b1;
            end
            tcw_pkg::ST_DRAIN:
            begin
                mem_req.we    = pend_reg;
                mem_req.waddr = pend_addr_reg;
                mem_req.wdata = mem_rdata;
            end
            tcw_pkg::ST_FILL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg;
                if (!zero_fill_reg && (cnt_reg < BOTTOM_ROW))
                begin
                    mem_req.wdata = {def_attr, tcw_pkg::SPACE_CODE};
                end
                if (cnt_reg == LAST_CELL)
                begin
                    init_next = 1'b0;
                    done_next = !init_reg;
                    res_next  = '{cursor_cell: 11'(cur_addr), scrolled: 1'b1,
                                  read_character: 8'd0, read_attribute: 8'd0};
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                mem_req.we = 1'b0;
            end
        endcase
    end

    // control registers; reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_FILL;
            cnt_reg       <= '0;
            zero_fill_reg <= 1'b1;
            init_reg      <= 1'b1;
            pend_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            zero_fill_reg <= zero_fill_next;
            init_reg      <= init_next;
            pend_reg      <= pend_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            done_reg      <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        res_reg       <= res_next;
    end

    assign busy   = (state_reg != tcw_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // cursor always stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < tcw_pkg::COLUMNS) && (32'(row_reg) < tcw_pkg::ROWS))
        else $error("cursor off screen");

    // scroll copy never writes the cell it is reading
    a_copy_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcw_pkg::ST_COPY) && mem_req.we |-> mem_req.waddr != mem_req.raddr)
        else $error("scroll copy address overlap");

    // every accepted item either finishes next cycle or keeps the block busy
    a_item_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done || busy)
        else $error("accepted item lost");

    // a result never comes from a scroll copy cycle
    a_done_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) != tcw_pkg::ST_COPY)
        else $error("result during scroll copy");

endmodule

// ===== hdl/text_console_writer.sv =====
// text console writer top level: 80x25 cell memory, cursor and command sequencer
//
// A put without a scroll leaves busy low and its result strobes on the next
// cycle, as does that of a no-operation item; a read first passes the read state,
// which takes the registered cell memory data. A put that moves past the last
// cell scrolls through the simple dual-port cell memory, one cell per cycle: the
// copy of the upper rows, a drain step and the zeroing of the bottom row follow
// in that order. A clear writes every cell once. After reset the block sweeps the
// whole memory to zero with busy high; configuration writes are taken at any
// time. done marks each result for exactly one cycle and cannot be held off.
module text_console_writer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tcw_pkg::cmd_t     cmd,
    output logic              done,
    output tcw_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);

    logic [7:0]                 def_attr_reg, def_attr_next;
    tcw_pkg::mem_req_t          mem_req;
    logic [tcw_pkg::CELL_W-1:0] mem_rdata;

    // default attribute register, written on a config transfer
    always_comb
    begin
        def_attr_next = def_attr_reg;
        if (cfg_valid && cfg_ready)
        begin
            def_attr_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_attr_reg <= tcw_pkg::DEFAULT_ATTR_RESET;
        end
        else
        begin
            def_attr_reg <= def_attr_next;
        end
    end

    assign cfg_ready = 1'b1;

    // command sequencer
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .def_attr  (def_attr_reg),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // cell memory
    tcw_ram #(
        .DEPTH  (tcw_pkg::CELLS),
        .WIDTH  (tcw_pkg::CELL_W),
        .ADDR_W (tcw_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule
